### sv/rbpa_pkg.sv
// Shared types and constants for the region bump page allocator.
// No dependencies; used by rbpa_ctrl, rbpa_datapath and the top level.
`default_nettype none

package rbpa_pkg;

    localparam int DEFAULT_MAX_REGIONS = 32;

    localparam int ADDR_W       = 32;
    localparam int WIDE_W       = 64;
    localparam int TYPE_W       = 32;
    localparam int PAGE_COUNT_W = 21;
    localparam int PAGE_SHIFT   = 12;
    localparam int SIZE_W       = PAGE_COUNT_W + PAGE_SHIFT;
    localparam int END_W        = SIZE_W + 1;

    localparam logic [ADDR_W-1:0] ALIGN_MASK  = ~((ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1));
    localparam logic [ADDR_W-1:0] PAGE_ROUND  = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);
    localparam logic [TYPE_W-1:0] USABLE_TYPE = TYPE_W'(1);

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    typedef struct packed {
        logic init;         // empty table (reset fill count and index), reload next-free address
        logic load;         // append region at fill count
        logic latch_count;  // capture page count of an allocate
        logic advance;      // step to next region
        logic raise;        // lift next-free address to region start
        logic commit;       // bump next-free address past the allocation
        logic res_en;       // emit a result beat
        logic res_fail;
        logic res_nfa;      // result address is the next-free address
    } rbpa_cmd_t;

    typedef struct packed {
        logic table_full;
        logic pre_fail;
        logic fits;
        logic has_next;
    } rbpa_status_t;

endpackage

`default_nettype wire

### sv/rbpa_datapath.sv
// Datapath of the page allocator: region table memory, counters, next-free
// address and result registers. Depends on rbpa_pkg.
`default_nettype none

module rbpa_datapath #(
    parameter int MAX_REGIONS = rbpa_pkg::DEFAULT_MAX_REGIONS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rbpa_pkg::rbpa_cmd_t                cmd,
    output rbpa_pkg::rbpa_status_t                  status,
    input  wire logic                               cfg_write_en,
    input  wire logic [rbpa_pkg::ADDR_W-1:0]        image_end_address,
    input  wire logic [rbpa_pkg::WIDE_W-1:0]        region_base,
    input  wire logic [rbpa_pkg::WIDE_W-1:0]        region_length,
    input  wire logic [rbpa_pkg::TYPE_W-1:0]        region_type,
    input  wire logic [rbpa_pkg::PAGE_COUNT_W-1:0]  page_count,
    output logic                                    done,
    output logic [rbpa_pkg::ADDR_W-1:0]             page_address,
    output logic                                    failed
);

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int AW    = rbpa_pkg::ADDR_W;

    // region table, no reset: only entries below the fill count are used
    logic [AW-1:0] start_mem  [MAX_REGIONS];
    logic [AW-1:0] limit_mem  [MAX_REGIONS];
    logic          usable_mem [MAX_REGIONS];

    logic [AW-1:0] rd_start_reg;
    logic [AW-1:0] rd_limit_reg;
    logic          rd_usable_reg;

    logic [AW-1:0]                     image_end_reg;
    logic [CNT_W-1:0]                  loaded_reg, loaded_next;
    logic [CNT_W-1:0]                  current_reg, current_next;
    logic [AW-1:0]                     nfa_reg, nfa_next;
    logic [rbpa_pkg::PAGE_COUNT_W-1:0] count_reg;
    logic                              done_reg;
    logic [AW-1:0]                     page_address_reg;
    logic                              failed_reg;

    logic [rbpa_pkg::SIZE_W-1:0] size;
    logic [rbpa_pkg::END_W-1:0]  end_sum;
    logic [CNT_W:0]              current_inc;
    logic [AW-1:0]               load_limit;

    assign size        = {count_reg, rbpa_pkg::PAGE_SHIFT'(0)};
    assign end_sum     = rbpa_pkg::END_W'(nfa_reg) + rbpa_pkg::END_W'(size);
    assign current_inc = {1'b0, current_reg} + (CNT_W + 1)'(1);
    assign load_limit  = region_base[AW-1:0] + region_length[AW-1:0];

    assign status.table_full = (loaded_reg == CNT_W'(MAX_REGIONS));
    assign status.pre_fail   = (count_reg == '0) || (current_reg >= loaded_reg)
                               || (end_sum[rbpa_pkg::END_W-1:AW] != '0);
    assign status.fits       = rd_usable_reg && (nfa_reg >= rd_start_reg)
                               && (end_sum < rbpa_pkg::END_W'(rd_limit_reg));
    assign status.has_next   = (current_inc < {1'b0, loaded_reg});

    always_comb
    begin
        loaded_next  = loaded_reg;
        current_next = current_reg;
        nfa_next     = nfa_reg;
        if (cmd.init)
        begin
            loaded_next  = '0;
            current_next = '0;
            nfa_next     = (image_end_reg + rbpa_pkg::PAGE_ROUND) & rbpa_pkg::ALIGN_MASK;
        end
        if (cmd.load)
        begin
            loaded_next = loaded_reg + CNT_W'(1);
        end
        if (cmd.advance)
        begin
            current_next = current_inc[CNT_W-1:0];
        end
        if (cmd.raise && (nfa_reg < rd_start_reg))
        begin
            nfa_next = rd_start_reg;
        end
        if (cmd.commit)
        begin
            nfa_next = end_sum[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_mem[loaded_reg[IDX_W-1:0]]  <= region_base[AW-1:0];
            limit_mem[loaded_reg[IDX_W-1:0]]  <= load_limit;
            usable_mem[loaded_reg[IDX_W-1:0]] <= (region_type == rbpa_pkg::USABLE_TYPE);
        end
        rd_start_reg  <= start_mem[current_reg[IDX_W-1:0]];
        rd_limit_reg  <= limit_mem[current_reg[IDX_W-1:0]];
        rd_usable_reg <= usable_mem[current_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_count)
        begin
            count_reg <= page_count;
        end
        if (cmd.res_en)
        begin
            page_address_reg <= cmd.res_nfa ? nfa_reg : '0;
            failed_reg       <= cmd.res_fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_end_reg <= '0;
            loaded_reg    <= '0;
            current_reg   <= '0;
            nfa_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                image_end_reg <= image_end_address;
            end
            loaded_reg  <= loaded_next;
            current_reg <= current_next;
            nfa_reg     <= nfa_next;
            done_reg    <= cmd.res_en;
        end
    end

    assign done         = done_reg;
    assign page_address = page_address_reg;
    assign failed       = failed_reg;

endmodule

`default_nettype wire

### sv/rbpa_ctrl.sv
// Controller of the page allocator: decodes commands and sequences the
// region walk of an allocate. Depends on rbpa_pkg.
`default_nettype none

module rbpa_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [1:0]             opcode,
    input  wire rbpa_pkg::rbpa_status_t status,
    output rbpa_pkg::rbpa_cmd_t         cmd,
    output logic                        busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;  // count, exhaustion, overflow checks
    localparam logic [2:0] ST_FIT   = 3'd2;  // test current region
    localparam logic [2:0] ST_ADV   = 3'd3;  // table read of new region in flight
    localparam logic [2:0] ST_RAISE = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        rbpa_pkg::OP_INIT:
                        begin
                            cmd.init   = 1'b1;
                            cmd.res_en = 1'b1;
                        end
                        rbpa_pkg::OP_LOAD:
                        begin
                            cmd.load     = !status.table_full;
                            cmd.res_en   = 1'b1;
                            cmd.res_fail = status.table_full;
                        end
                        rbpa_pkg::OP_ALLOC:
                        begin
                            cmd.latch_count = 1'b1;
                            state_next      = ST_PRE;
                        end
                        default:
                        begin
                            cmd.res_en = 1'b1;
                        end
                    endcase
                end
            end
            ST_PRE:
            begin
                if (status.pre_fail)
                begin
                    cmd.res_en   = 1'b1;
                    cmd.res_fail = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FIT;
                end
            end
            ST_FIT:
            begin
                if (status.fits)
                begin
                    cmd.commit  = 1'b1;
                    cmd.res_en  = 1'b1;
                    cmd.res_nfa = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    if (status.has_next)
                    begin
                        state_next = ST_ADV;
                    end
                    else
                    begin
                        // walk ran off the table; index is left at the fill count
                        cmd.res_en   = 1'b1;
                        cmd.res_fail = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_ADV:
            begin
                state_next = ST_RAISE;
            end
            ST_RAISE:
            begin
                cmd.raise  = 1'b1;
                state_next = ST_FIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

### sv/region_bump_page_allocator.sv
// Top level of the region bump page allocator: controller plus datapath.
// Depends on rbpa_pkg, rbpa_ctrl and rbpa_datapath.
//
//   channel   handshake            payload
//   command   start / busy         opcode, region_base, region_length,
//                                  region_type, page_count
//   result    done (1-cycle beat)  page_address, failed
//   config    cfg_write_en         image_end_address
//
// Init, load and unused opcodes: busy stays low; the result beat shows the
// cycle after accept, while the next command may already be taken.
// Allocate: busy ends in ST_PRE on an early fail (zero count, no region left,
// overflow), else in ST_FIT after the region walk; the beat shows as busy drops.
// Reset clears counters and the next-free address; the table is not cleared.
// The receiver cannot stall: every result beat is taken as it appears.
`default_nettype none

module region_bump_page_allocator #(
    parameter int MAX_REGIONS = rbpa_pkg::DEFAULT_MAX_REGIONS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         opcode,
    input  wire logic [rbpa_pkg::WIDE_W-1:0]        region_base,
    input  wire logic [rbpa_pkg::WIDE_W-1:0]        region_length,
    input  wire logic [rbpa_pkg::TYPE_W-1:0]        region_type,
    input  wire logic [rbpa_pkg::PAGE_COUNT_W-1:0]  page_count,
    input  wire logic                               cfg_write_en,
    input  wire logic [rbpa_pkg::ADDR_W-1:0]        image_end_address,
    output logic                                    done,
    output logic [rbpa_pkg::ADDR_W-1:0]             page_address,
    output logic                                    failed
);

    rbpa_pkg::rbpa_cmd_t    cmd;
    rbpa_pkg::rbpa_status_t status;

    rbpa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    rbpa_datapath #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_write_en      (cfg_write_en),
        .image_end_address (image_end_address),
        .region_base       (region_base),
        .region_length     (region_length),
        .region_type       (region_type),
        .page_count        (page_count),
        .done              (done),
        .page_address      (page_address),
        .failed            (failed)
    );

endmodule

`default_nettype wire
